@@ sv/cft_pkg.sv @@
// Shared types, constants and name lookups for the cron field tokenizer.
`timescale 1ns / 1ps

package cft_pkg;

    // Default longest string; positions saturate one below this
    localparam int CFT_MAX_LEN = 256;

    // Result queue depth
    localparam int CFT_QDEPTH = 4;

    // Token kinds
    localparam logic [3:0] K_END     = 4'd0;
    localparam logic [3:0] K_INT     = 4'd1;
    localparam logic [3:0] K_INTW    = 4'd2;
    localparam logic [3:0] K_INTL    = 4'd3;
    localparam logic [3:0] K_STAR    = 4'd4;
    localparam logic [3:0] K_QUEST   = 4'd5;
    localparam logic [3:0] K_DASH    = 4'd6;
    localparam logic [3:0] K_COMMA   = 4'd7;
    localparam logic [3:0] K_SLASH   = 4'd8;
    localparam logic [3:0] K_HASH    = 4'd9;
    localparam logic [3:0] K_L       = 4'd10;
    localparam logic [3:0] K_W       = 4'd11;
    localparam logic [3:0] K_MONTH   = 4'd12;
    localparam logic [3:0] K_WEEKDAY = 4'd13;
    localparam logic [3:0] K_ERROR   = 4'd14;

    // Character codes
    localparam logic [15:0] CH_NUL    = 16'h0000;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_DASH   = 16'h002D;
    localparam logic [15:0] CH_COMMA  = 16'h002C;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_HASH   = 16'h0023;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_QUEST  = 16'h003F;
    localparam logic [15:0] CH_0      = 16'h0030;
    localparam logic [15:0] CH_9      = 16'h0039;
    localparam logic [15:0] CH_UA     = 16'h0041;
    localparam logic [15:0] CH_UZ     = 16'h005A;
    localparam logic [15:0] CH_LA     = 16'h0061;
    localparam logic [15:0] CH_LZ     = 16'h007A;
    localparam logic [15:0] CH_W      = 16'h0057;
    localparam logic [15:0] CH_L      = 16'h004C;

    // Scanner phase
    typedef enum logic [3:0] {
        PH_START,
        PH_SKIP,
        PH_STAR,
        PH_INT,
        PH_INTW,
        PH_INTL,
        PH_A1,
        PH_A2,
        PH_A3,
        PH_DEAD
    } t_phase;

    // Scanner state apart from the positions
    typedef struct packed {
        t_phase      phase;
        logic [15:0] acc;
        logic [6:0]  let0;
        logic [6:0]  let1;
        logic [6:0]  let2;
    } t_state;

    // One result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic [7:0]  offset;
        logic [2:0]  err_field;
        logic        last;
    } t_res;

    // Outcome of a name lookup
    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_lookup;

    // Packs three ASCII letters into 21 bits
    function automatic logic [20:0] pack3(input logic [23:0] s);
        return {s[22:16], s[14:8], s[6:0]};
    endfunction

    // Month names JAN..DEC give 0..11
    function automatic t_lookup month_lookup(input logic [20:0] n);
        t_lookup r;
        r.hit = 1'b1;
        case (n)
            pack3("JAN"): r.idx = 4'd0;
            pack3("FEB"): r.idx = 4'd1;
            pack3("MAR"): r.idx = 4'd2;
            pack3("APR"): r.idx = 4'd3;
            pack3("MAY"): r.idx = 4'd4;
            pack3("JUN"): r.idx = 4'd5;
            pack3("JUL"): r.idx = 4'd6;
            pack3("AUG"): r.idx = 4'd7;
            pack3("SEP"): r.idx = 4'd8;
            pack3("OCT"): r.idx = 4'd9;
            pack3("NOV"): r.idx = 4'd10;
            pack3("DEC"): r.idx = 4'd11;
            default: begin
                r.hit = 1'b0;
                r.idx = 4'd0;
            end
        endcase
        return r;
    endfunction

    // Weekday names SUN..SAT give 0..6
    function automatic t_lookup wday_lookup(input logic [20:0] n);
        t_lookup r;
        r.hit = 1'b1;
        case (n)
            pack3("SUN"): r.idx = 4'd0;
            pack3("MON"): r.idx = 4'd1;
            pack3("TUE"): r.idx = 4'd2;
            pack3("WED"): r.idx = 4'd3;
            pack3("THU"): r.idx = 4'd4;
            pack3("FRI"): r.idx = 4'd5;
            pack3("SAT"): r.idx = 4'd6;
            default: begin
                r.hit = 1'b0;
                r.idx = 4'd0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/cft_step.sv @@
// Next-state and result logic for one character of the tokenizer.
`timescale 1ns / 1ps

module cft_step #(
    parameter int MAX_LEN = cft_pkg::CFT_MAX_LEN,
    parameter int POS_W   = $clog2(MAX_LEN)
) (
    input  logic [15:0]         i_char,
    input  cft_pkg::t_state     i_state,
    input  logic [POS_W-1:0]    i_pos,
    input  logic [POS_W-1:0]    i_tstart,
    input  logic [2:0]          i_field_kind,
    output cft_pkg::t_state     o_state,
    output logic [POS_W-1:0]    o_pos,
    output logic [POS_W-1:0]    o_tstart,
    output logic [1:0]          o_cnt,
    output cft_pkg::t_res       o_res0,
    output cft_pkg::t_res       o_res1
);
    import cft_pkg::*;

    logic        is_nul, is_sp, is_dig, is_alpha, is_fol, is_sp_end;
    logic [3:0]  dk;
    logic [7:0]  pos_off, ts_off;
    logic [19:0] acc_mul;
    logic [19:0] acc_sum;
    logic [15:0] acc_next;
    t_lookup     mon, wdy;

    // begin-of-token evaluation
    logic        beg_emit;
    t_res        beg_res;
    t_state      beg_state;
    logic [POS_W-1:0] beg_tstart;
    logic        allow_delim;

    // token closed by this character
    logic        tok_emit;
    t_res        tok_res;
    logic        do_beg;
    t_state      n_state;

    // Character classes
    always_comb begin
        is_nul    = (i_char == CH_NUL);
        is_sp     = (i_char == CH_SPACE) || (i_char >= CH_TAB && i_char <= CH_CR);
        is_dig    = (i_char >= CH_0) && (i_char <= CH_9);
        is_alpha  = (i_char >= CH_UA && i_char <= CH_UZ) ||
                    (i_char >= CH_LA && i_char <= CH_LZ);
        is_sp_end = is_nul || (i_char == CH_SPACE);
        is_fol    = is_sp_end || (i_char == CH_COMMA) || (i_char == CH_DASH) ||
                    (i_char == CH_SLASH) || (i_char == CH_HASH);
        case (i_char)
            CH_DASH:  dk = K_DASH;
            CH_COMMA: dk = K_COMMA;
            CH_SLASH: dk = K_SLASH;
            CH_HASH:  dk = K_HASH;
            default:  dk = K_END;
        endcase
    end

    // Offsets clamp at 255
    assign pos_off = (32'(i_pos) > 32'd255)    ? 8'hFF : 8'(i_pos);
    assign ts_off  = (32'(i_tstart) > 32'd255) ? 8'hFF : 8'(i_tstart);

    // Decimal accumulate with saturation
    always_comb begin
        acc_mul  = {1'b0, i_state.acc, 3'b000} + {3'b000, i_state.acc, 1'b0};
        acc_sum  = acc_mul + {16'd0, i_char[3:0]};
        acc_next = (acc_sum > 20'hFFFF) ? 16'hFFFF : acc_sum[15:0];
    end

    // Name lookups
    assign mon = month_lookup({i_state.let0, i_state.let1, i_state.let2});
    assign wdy = wday_lookup({i_state.let0, i_state.let1, i_state.let2});

    // Character taken as the start of a token search
    always_comb begin
        allow_delim = (i_state.phase != PH_SKIP);
        beg_emit    = 1'b0;
        beg_state   = i_state;
        beg_tstart  = i_tstart;
        beg_res     = '{kind: K_END, value: 16'd0, offset: pos_off,
                        err_field: 3'd0, last: 1'b0};
        if (is_nul) begin
            beg_emit = 1'b1;
        end else if (allow_delim && dk != K_END) begin
            beg_emit        = 1'b1;
            beg_res.kind    = dk;
            beg_state.phase = PH_START;
        end else begin
            beg_tstart = i_pos;
            if (is_sp) begin
                beg_state.phase = PH_SKIP;
            end else if (i_char == CH_STAR || i_char == CH_QUEST) begin
                beg_state.acc   = (i_char == CH_STAR) ? 16'(K_STAR) : 16'(K_QUEST);
                beg_state.phase = PH_STAR;
            end else if (is_dig) begin
                beg_state.acc   = {12'd0, i_char[3:0]};
                beg_state.phase = PH_INT;
            end else if (is_alpha) begin
                beg_state.let0  = i_char[6:0];
                beg_state.phase = PH_A1;
            end else begin
                beg_emit          = 1'b1;
                beg_res.kind      = K_ERROR;
                beg_res.err_field = i_field_kind;
                beg_state.phase   = PH_DEAD;
            end
        end
    end

    // Phase handling
    always_comb begin
        n_state  = i_state;
        tok_emit = 1'b0;
        do_beg   = 1'b0;
        tok_res  = '{kind: K_ERROR, value: 16'd0, offset: ts_off,
                     err_field: i_field_kind, last: 1'b0};
        case (i_state.phase)
            PH_START, PH_SKIP: begin
                do_beg = 1'b1;
            end
            PH_STAR: begin
                tok_emit = 1'b1;
                if (is_sp_end) begin
                    tok_res.kind      = i_state.acc[3:0];
                    tok_res.err_field = 3'd0;
                    do_beg            = 1'b1;
                end else begin
                    n_state.phase = PH_DEAD;
                end
            end
            PH_INT: begin
                if (is_dig) begin
                    n_state.acc = acc_next;
                end else if (i_char == CH_W) begin
                    n_state.phase = PH_INTW;
                end else if (i_char == CH_L) begin
                    n_state.phase = PH_INTL;
                end else if (is_fol) begin
                    tok_emit          = 1'b1;
                    tok_res.kind      = K_INT;
                    tok_res.value     = i_state.acc;
                    tok_res.err_field = 3'd0;
                    do_beg            = 1'b1;
                end else begin
                    tok_emit      = 1'b1;
                    n_state.phase = PH_DEAD;
                end
            end
            PH_INTW, PH_INTL: begin
                tok_emit = 1'b1;
                if (is_fol) begin
                    tok_res.kind      = (i_state.phase == PH_INTW) ? K_INTW : K_INTL;
                    tok_res.value     = i_state.acc;
                    tok_res.err_field = 3'd0;
                    do_beg            = 1'b1;
                end else begin
                    n_state.phase = PH_DEAD;
                end
            end
            PH_A1: begin
                if (is_alpha) begin
                    n_state.let1  = i_char[6:0];
                    n_state.phase = PH_A2;
                end else if ((is_sp_end || i_char == CH_COMMA) &&
                             (i_state.let0 == CH_L[6:0] || i_state.let0 == CH_W[6:0])) begin
                    tok_emit          = 1'b1;
                    tok_res.kind      = (i_state.let0 == CH_L[6:0]) ? K_L : K_W;
                    tok_res.err_field = 3'd0;
                    do_beg            = 1'b1;
                end else begin
                    tok_emit      = 1'b1;
                    n_state.phase = PH_DEAD;
                end
            end
            PH_A2: begin
                if (is_alpha) begin
                    n_state.let2  = i_char[6:0];
                    n_state.phase = PH_A3;
                end else begin
                    tok_emit      = 1'b1;
                    n_state.phase = PH_DEAD;
                end
            end
            PH_A3: begin
                tok_emit = 1'b1;
                if (is_fol && mon.hit) begin
                    tok_res.kind      = K_MONTH;
                    tok_res.value     = {12'd0, mon.idx};
                    tok_res.err_field = 3'd0;
                    do_beg            = 1'b1;
                end else if (is_fol && wdy.hit) begin
                    tok_res.kind      = K_WEEKDAY;
                    tok_res.value     = {12'd0, wdy.idx};
                    tok_res.err_field = 3'd0;
                    do_beg            = 1'b1;
                end else begin
                    n_state.phase = PH_DEAD;
                end
            end
            default: begin
                // dead: swallow the rest of the string
            end
        endcase
    end

    // Merge, end-of-string handling and result ordering
    always_comb begin
        o_state  = do_beg ? beg_state : n_state;
        o_tstart = do_beg ? beg_tstart : i_tstart;
        if (is_nul) begin
            o_state.phase = PH_START;
            o_pos         = '0;
        end else if (32'(i_pos) < MAX_LEN - 1) begin
            o_pos = i_pos + POS_W'(1);
        end else begin
            o_pos = i_pos;
        end

        o_res0 = tok_res;
        o_res1 = beg_res;
        o_cnt  = 2'd0;
        if (tok_emit && do_beg && beg_emit) begin
            o_cnt       = 2'd2;
            o_res1.last = 1'b1;
        end else if (tok_emit) begin
            o_cnt       = 2'd1;
            o_res0.last = 1'b1;
        end else if (do_beg && beg_emit) begin
            o_cnt       = 2'd1;
            o_res0      = beg_res;
            o_res0.last = 1'b1;
        end
    end

endmodule

@@ sv/cft_outq.sv @@
// Result queue: takes up to two results a cycle, gives one a cycle while the receiver is ready.
`timescale 1ns / 1ps

module cft_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push,
    input  cft_pkg::t_res  i_res0,
    input  cft_pkg::t_res  i_res1,
    output logic           o_room2,
    output logic           o_valid,
    input  logic           i_ready,
    output cft_pkg::t_res  o_res
);
    import cft_pkg::*;

    localparam int PTR_W = $clog2(CFT_QDEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_res             r_mem [CFT_QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rp];

    // Two free slots, counting the one leaving this cycle
    assign o_room2 = (32'(r_cnt) <= CFT_QDEPTH - 2) ||
                     ((32'(r_cnt) == CFT_QDEPTH - 1) && pop);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(i_push);
            r_rp  <= r_rp + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_res1;
        end
    end

endmodule

@@ sv/cron_field_tokenizer.sv @@
// Top level of the cron field tokenizer: input register, scanner state, result queue.
`timescale 1ns / 1ps

// Splits the text of one cron field into tokens, one character per request.
// Input channel: i_valid / o_ready with i_char_code; a code of 0 ends the
// string and produces the end token, unless the string gave an error token.
// Output channel: o_valid / i_ready with one token per request; o_last marks
// the final token caused by a character. A character may give no token, one,
// or two (a token plus the delimiter or end that follows it).
// A character is registered on acceptance, then scanned once two queue slots
// are free; its tokens are written into the result queue and offered from it.
// Throughput: one character per cycle while the tokens are taken as fast as
// they come; the four-entry result queue sets the limit, since a character
// is scanned only when two slots are free.
// i_cfg_we / i_cfg_wdata write the field kind echoed in error tokens; write
// it only while the block is idle.
// Synchronous reset (i_rst_n low) empties the queue, drops a held character
// and returns the scanner to the start of a new string with field kind 0.
// When the receiver stalls, the queue fills and o_ready falls; nothing is lost.
module cron_field_tokenizer #(
    parameter int MAX_LEN = cft_pkg::CFT_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_char_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_value,
    output logic [7:0]  o_offset,
    output logic [2:0]  o_error_field,
    output logic        o_last
);
    import cft_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN);

    logic             r_in_vld;
    logic [15:0]      r_char;
    logic [2:0]       r_field_kind;
    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_tstart, n_tstart;

    logic [1:0]       step_cnt;
    t_res             res0, res1, q_res;
    logic             room2, step_go;
    logic [1:0]       push;

    // Scan the held character once the queue has room for both results
    assign step_go = r_in_vld && room2;
    assign o_ready = !r_in_vld || step_go;
    assign push    = step_go ? step_cnt : 2'd0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_char <= i_char_code;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_kind <= 3'd0;
        end else if (i_cfg_we) begin
            r_field_kind <= i_cfg_wdata;
        end
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '{phase: PH_START, acc: 16'd0, let0: 7'd0, let1: 7'd0, let2: 7'd0};
            r_pos    <= '0;
            r_tstart <= '0;
        end else if (step_go) begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
        end
    end

    cft_step #(
        .MAX_LEN (MAX_LEN),
        .POS_W   (POS_W)
    ) u_step (
        .i_char       (r_char),
        .i_state      (r_state),
        .i_pos        (r_pos),
        .i_tstart     (r_tstart),
        .i_field_kind (r_field_kind),
        .o_state      (n_state),
        .o_pos        (n_pos),
        .o_tstart     (n_tstart),
        .o_cnt        (step_cnt),
        .o_res0       (res0),
        .o_res1       (res1)
    );

    cft_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room2 (room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (q_res)
    );

    // Result fields
    assign o_token_kind  = q_res.kind;
    assign o_token_value = q_res.value;
    assign o_offset      = q_res.offset;
    assign o_error_field = q_res.err_field;
    assign o_last        = q_res.last;

endmodule

@@ test/cron_field_tokenizer_tb.sv @@
// Self-checking testbench for the cron field tokenizer: directed and random strings against a scanner model.
`timescale 1ns / 1ps

module cron_field_tokenizer_tb;

    import cft_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 8;
    localparam int PHASE_CHARS   = 280;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int REPORT_CAP    = 40;

    // Receiver stall patterns
    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    // What may follow a generated token
    localparam int FOL_SPACE = 0;
    localparam int FOL_LIST  = 1;
    localparam int FOL_ANY   = 2;

    localparam string MONTH_NAMES = "JANFEBMARAPRMAYJUNJULAUGSEPOCTNOVDEC";
    localparam string WDAY_NAMES  = "SUNMONTUEWEDTHUFRISAT";

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_wdata   = 3'd0;
    logic        i_valid       = 1'b0;
    logic [15:0] i_char_code   = 16'd0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_value;
    logic [7:0]  o_offset;
    logic [2:0]  o_error_field;
    logic        o_last;

    // Characters waiting to be sent, and tokens predicted but not yet seen
    logic [15:0] char_feed[$];
    t_res        pending_tokens[$];
    t_res        step_toks[$];

    // Scanner model state
    t_phase      scan_phase = PH_START;
    int          scan_acc   = 0;
    logic [15:0] scan_let[3];
    int          scan_pos   = 0;
    int          scan_start = 0;
    logic [2:0]  fld_kind   = 3'd0;

    int fail_count  = 0;
    int noise_rate  = 0;
    int cycle_count = 0;

    // Sender burst control
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall control
    int rx_cycle   = 0;
    int rx_mode    = RX_OPEN;
    int hold_left  = 0;
    int holds_done = 0;

    cron_field_tokenizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_offset      (o_offset),
        .o_error_field (o_error_field),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------

    function automatic bit is_ws(input logic [15:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_num(input logic [15:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_letter(input logic [15:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    function automatic bit is_follow(input logic [15:0] c);
        return c == CH_NUL || c == CH_SPACE || c == CH_COMMA || c == CH_DASH ||
               c == CH_SLASH || c == CH_HASH;
    endfunction

    // Delimiter token for c, or K_END when c is no delimiter
    function automatic logic [3:0] delim_of(input logic [15:0] c);
        case (c)
            CH_DASH:  return K_DASH;
            CH_COMMA: return K_COMMA;
            CH_SLASH: return K_SLASH;
            CH_HASH:  return K_HASH;
            default:  return K_END;
        endcase
    endfunction

    function automatic int name_index(input string names, input int count);
        for (int i = 0; i < count; i++) begin
            if (scan_let[0] == {8'h00, names[3*i]} &&
                scan_let[1] == {8'h00, names[3*i+1]} &&
                scan_let[2] == {8'h00, names[3*i+2]})
                return i;
        end
        return -1;
    endfunction

    task automatic emit(input logic [3:0] kind, input int val, input int off);
        t_res r;
        r.kind      = kind;
        r.value     = val[15:0];
        r.offset    = (off > 255) ? 8'd255 : off[7:0];
        r.err_field = (kind == K_ERROR) ? fld_kind : 3'd0;
        r.last      = 1'b0;
        step_toks.push_back(r);
    endtask

    // Bad sequence: report at the token start, drop the rest of the string
    task automatic reject();
        scan_phase = PH_DEAD;
        emit(K_ERROR, 0, scan_start);
    endtask

    // c opens a new token search
    task automatic open_token(input logic [15:0] c, input bit allow_delim);
        logic [3:0] dk;
        dk = delim_of(c);
        if (c == CH_NUL) begin
            emit(K_END, 0, scan_pos);
        end else if (allow_delim && dk != K_END) begin
            scan_phase = PH_START;
            emit(dk, 0, scan_pos);
        end else begin
            scan_start = scan_pos;
            if (is_ws(c)) begin
                scan_phase = PH_SKIP;
            end else if (c == CH_STAR || c == CH_QUEST) begin
                scan_acc   = int'((c == CH_STAR) ? K_STAR : K_QUEST);
                scan_phase = PH_STAR;
            end else if (is_num(c)) begin
                scan_acc   = int'(c - CH_0);
                scan_phase = PH_INT;
            end else if (is_letter(c)) begin
                scan_let[0] = c;
                scan_phase  = PH_A1;
            end else begin
                reject();
            end
        end
    endtask

    // One accepted character: advance the model and queue the tokens it gives
    task automatic scan_char(input logic [15:0] c);
        int mi;
        int wi;
        step_toks.delete();
        case (scan_phase)
            PH_START: open_token(c, 1'b1);
            PH_SKIP:  open_token(c, 1'b0);
            PH_STAR: begin
                if (c == CH_NUL || c == CH_SPACE) begin
                    emit(scan_acc[3:0], 0, scan_start);
                    open_token(c, 1'b1);
                end else begin
                    reject();
                end
            end
            PH_INT: begin
                if (is_num(c)) begin
                    scan_acc = scan_acc * 10 + int'(c - CH_0);
                    if (scan_acc > 65535) scan_acc = 65535;
                end else if (c == CH_W) begin
                    scan_phase = PH_INTW;
                end else if (c == CH_L) begin
                    scan_phase = PH_INTL;
                end else if (is_follow(c)) begin
                    emit(K_INT, scan_acc, scan_start);
                    open_token(c, 1'b1);
                end else begin
                    reject();
                end
            end
            PH_INTW, PH_INTL: begin
                if (is_follow(c)) begin
                    emit(scan_phase == PH_INTW ? K_INTW : K_INTL, scan_acc, scan_start);
                    open_token(c, 1'b1);
                end else begin
                    reject();
                end
            end
            PH_A1: begin
                if (is_letter(c)) begin
                    scan_let[1] = c;
                    scan_phase  = PH_A2;
                end else if ((c == CH_NUL || c == CH_SPACE || c == CH_COMMA) &&
                             (scan_let[0] == CH_L || scan_let[0] == CH_W)) begin
                    emit(scan_let[0] == CH_L ? K_L : K_W, 0, scan_start);
                    open_token(c, 1'b1);
                end else begin
                    reject();
                end
            end
            PH_A2: begin
                if (is_letter(c)) begin
                    scan_let[2] = c;
                    scan_phase  = PH_A3;
                end else begin
                    reject();
                end
            end
            PH_A3: begin
                mi = name_index(MONTH_NAMES, 12);
                wi = name_index(WDAY_NAMES, 7);
                if (is_follow(c) && mi >= 0) begin
                    emit(K_MONTH, mi, scan_start);
                    open_token(c, 1'b1);
                end else if (is_follow(c) && wi >= 0) begin
                    emit(K_WEEKDAY, wi, scan_start);
                    open_token(c, 1'b1);
                end else begin
                    reject();
                end
            end
            default: ;
        endcase

        // End of string restarts the scan; long strings pin the position
        if (c == CH_NUL) begin
            scan_phase = PH_START;
            scan_pos   = 0;
        end else if (scan_pos < CFT_MAX_LEN - 1) begin
            scan_pos++;
        end

        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[k]) pending_tokens.push_back(step_toks[k]);
    endtask

    // Model follows each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_phase = PH_START;
            scan_acc   = 0;
            scan_let   = '{16'd0, 16'd0, 16'd0};
            scan_pos   = 0;
            scan_start = 0;
            fld_kind   = 3'd0;
        end else if (i_valid && o_ready) begin
            scan_char(i_char_code);
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (i_valid && !o_ready) begin
            // request held until taken
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (char_feed.size() > 0) begin
            i_valid     <= 1'b1;
            i_char_code <= char_feed.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 12);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall pattern, plus long hold-offs to fill the block
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rx_cycle  = 0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (i_valid && ((holds_done == 0 && rx_cycle >= 1500) ||
                                     (holds_done == 1 && rx_cycle >= 6000))) begin
                holds_done++;
                hold_left = LONG_HOLD;
                i_ready <= 1'b0;
            end else begin
                if (rx_cycle % 64 == 0) rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
                case (rx_mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Token checker
    // ------------------------------------------------------------------

    task automatic check_field(input string fname, input int want, input int seen);
        if (want != seen) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, seen);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: unexpected token, expected none, got kind %0d value %0d",
                             $time, o_token_kind, o_token_value);
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", int'(want.kind), int'(o_token_kind));
                check_field("token_value", int'(want.value), int'(o_token_value));
                check_field("offset", int'(want.offset), int'(o_offset));
                check_field("error_field", int'(want.err_field), int'(o_error_field));
                check_field("last", int'(want.last), int'(o_last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cron_field_tokenizer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [15:0] pick_delim();
        case ($urandom_range(0, 3))
            0:       return CH_DASH;
            1:       return CH_COMMA;
            2:       return CH_SLASH;
            default: return CH_HASH;
        endcase
    endfunction

    function automatic logic [15:0] ws_code();
        if ($urandom_range(0, 1)) return CH_SPACE;
        return 16'(CH_TAB + $urandom_range(0, 4));
    endfunction

    function automatic logic [15:0] junk_code();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(33, 126));
            2:       return 16'(CH_LA + $urandom_range(0, 25));
            3:       return pick_delim();
            default: return ws_code();
        endcase
    endfunction

    // Queue one character, now and then swapped for junk in noisy strings
    task automatic push_code(input logic [15:0] c);
        logic [15:0] v;
        v = c;
        if (noise_rate > 0 && $urandom_range(0, noise_rate - 1) == 0) v = junk_code();
        char_feed.push_back(v);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_code({8'h00, s[k]});
    endtask

    task automatic push_name(input string names, input int idx, input bit lower);
        for (int k = 0; k < 3; k++)
            push_code({8'h00, names[3*idx+k]} + (lower ? 16'd32 : 16'd0));
    endtask

    // One token of random shape; fol says what may follow it
    task automatic push_random_token(output int fol);
        int nd;
        fol = FOL_ANY;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                nd = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 4);
                repeat (nd) push_code(16'(CH_0 + $urandom_range(0, 9)));
                case ($urandom_range(0, 5))
                    0:       push_code(CH_W);
                    1:       push_code(CH_L);
                    default: ;
                endcase
            end
            3: begin
                push_code($urandom_range(0, 1) ? CH_STAR : CH_QUEST);
                fol = FOL_SPACE;
            end
            4: begin
                push_code($urandom_range(0, 1) ? CH_L : CH_W);
                fol = FOL_LIST;
            end
            5, 6: push_name(MONTH_NAMES, $urandom_range(0, 11), $urandom_range(0, 15) == 0);
            7:    push_name(WDAY_NAMES, $urandom_range(0, 6), $urandom_range(0, 15) == 0);
            8: begin
                // arbitrary letters, mostly not a name
                nd = $urandom_range(1, 3);
                repeat (nd) push_code(16'(($urandom_range(0, 3) == 0 ? CH_LA : CH_UA) +
                                          $urandom_range(0, 25)));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       push_text("0");
                    1:       push_text("65535");
                    2:       push_text("65536");
                    default: push_text("99999999");
                endcase
            end
        endcase
    endtask

    task automatic push_separator(input int fol);
        case (fol)
            FOL_SPACE: push_code(CH_SPACE);
            FOL_LIST:  push_code($urandom_range(0, 1) ? CH_SPACE : CH_COMMA);
            default: begin
                case ($urandom_range(0, 6))
                    0, 1: push_code(CH_SPACE);
                    6: begin
                        // delimiter after whitespace is a broken sequence
                        push_code(CH_SPACE);
                        push_code(pick_delim());
                    end
                    default: push_code(pick_delim());
                endcase
            end
        endcase
        if ($urandom_range(0, 3) == 0) push_code(ws_code());
    endtask

    task automatic add_random_string();
        int ntok;
        int fol;
        int n;
        noise_rate = ($urandom_range(0, 3) == 0) ? 25 : 0;
        if ($urandom_range(0, 59) == 0) begin
            // long list, runs past the saturating position
            noise_rate = 0;
            n = $urandom_range(130, 170);
            repeat (n) begin
                push_code(16'(CH_0 + $urandom_range(0, 9)));
                push_code(CH_COMMA);
            end
            push_code(16'(CH_0 + $urandom_range(0, 9)));
        end else if ($urandom_range(0, 11) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) push_code(junk_code());
        end else begin
            if ($urandom_range(0, 9) == 0) push_code(pick_delim());
            ntok = $urandom_range(1, 6);
            for (int t = 0; t < ntok; t++) begin
                push_random_token(fol);
                if (t < ntok - 1) push_separator(fol);
            end
        end
        char_feed.push_back(CH_NUL);
    endtask

    task automatic set_field_kind(input logic [2:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        fld_kind = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Block idle: every request sent and every token seen, then a short settle
    task automatic wait_idle();
        while (char_feed.size() != 0 || i_valid || pending_tokens.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int fed_mark;
        int sent;
        logic [2:0] kind_val;

        while (!i_rst_n) @(negedge i_clk);

        // Directed strings, errors tagged with the top field kind
        set_field_kind(3'd7);
        noise_rate = 0;
        push_text("65536L/7W#3-W ?");
        push_code(CH_NUL);
        push_text("SUN,DEC/L,* ");
        push_code(CH_NUL);
        push_text("\tjan");
        push_code(CH_NUL);
        push_code(CH_SPACE);
        push_code(CH_STAR);
        push_code(16'hFFFF);
        push_code(CH_NUL);
        wait_idle();

        // Random phases, each under its own field kind
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                kind_val = 3'd0;
            else if (ph == PHASES - 1)
                kind_val = 3'd7;
            else
                kind_val = 3'($urandom_range(0, 7));
            set_field_kind(kind_val);
            sent = 0;
            while (sent < PHASE_CHARS) begin
                fed_mark = char_feed.size();
                add_random_string();
                sent += char_feed.size() - fed_mark;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("cron_field_tokenizer verification clean");
        else
            $display("cron_field_tokenizer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cft_pkg.sv
sv/cft_step.sv
sv/cft_outq.sv
sv/cron_field_tokenizer.sv
test/cron_field_tokenizer_tb.sv
